@@ hw/rtl/mftr_pkg.sv @@
`timescale 1ns / 1ps

package mftr_pkg;

  // Field widths
  localparam int ID_W    = 11;
  localparam int ENC_W   = 16;
  localparam int SPD_W   = 16;
  localparam int CUR_W   = 16;
  localparam int TEMP_W  = 8;
  localparam int SLOT_W  = 3;
  localparam int TURN_W  = 21;
  localparam int ANGLE_W = 35;

  // Identifier register file
  localparam int NUM_ID_REGS  = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int ID_RESET_BASE = 513;

  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_LEFT_ID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAR_LEFT_ID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_RIGHT_ID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REAR_RIGHT_ID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDER_ID      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURRET_ID      = 3'd5;

  // Multiturn tracking
  localparam int NUM_MOTORS_DEF = 6;
  localparam int JUMP_LIMIT     = 4096;
  localparam int TICK_SHIFT     = 13;   // 8192 ticks per turn
  localparam logic signed [TURN_W-1:0] TURN_MAX = 21'sh0FFFFF;
  localparam logic signed [TURN_W-1:0] TURN_MIN = 21'sh100000;

  // Queue depths
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // Classified frame, front to back
  typedef struct packed {
    logic        [SLOT_W-1:0] slot;
    logic        [ENC_W-1:0]  enc;
    logic signed [SPD_W-1:0]  speed;
    logic signed [CUR_W-1:0]  current;
    logic        [TEMP_W-1:0] temp;
  } cls_item_t;

  // Finished result
  typedef struct packed {
    logic        [SLOT_W-1:0]  slot;
    logic        [ENC_W-1:0]   enc;
    logic signed [SPD_W-1:0]   speed;
    logic signed [CUR_W-1:0]   current;
    logic        [TEMP_W-1:0]  temp;
    logic signed [TURN_W-1:0]  turns;
    logic signed [ANGLE_W-1:0] angle;
  } res_item_t;

  // Queue handshake toward a consumer
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

endpackage

@@ hw/rtl/motor_feedback_multiturn_tracker_core.sv @@
`timescale 1ns / 1ps

// Multiturn tracker for motor feedback frames.
// Input channel: drive the frame fields and raise push; a frame is taken on
// a clock edge where push is high and full is low. Only first-bus frames
// whose identifier matches a slot register produce a result; others are
// taken and dropped. Result channel: while empty is low the oldest result
// sits on the out_ ports; raise pop to take it.
// Config: cfg_we with cfg_index/cfg_wdata writes a slot identifier register
// at once; write only while no frames are in flight.
// A frame passes the front match into a two-entry queue, then the back
// read-modify-write of the slot record into a two-entry result queue.
// Throughput: one frame per cycle while the result queue is not full, set
// by the read-modify-write of the per-slot encoder and turn registers.
// Reset: identifiers return to 513..518, stored encoders and turn counts to
// zero, both queues empty. When pop stays low, results collect in the queues
// and full rises after four matching frames; nothing is lost.
module motor_feedback_multiturn_tracker_core #(
  parameter int NUM_MOTORS = mftr_pkg::NUM_MOTORS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_we,
  input  logic [mftr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mftr_pkg::ID_W-1:0]              cfg_wdata,
  // input queue side
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   in_bus_select,
  input  logic [mftr_pkg::ID_W-1:0]              in_frame_id,
  input  logic [mftr_pkg::ENC_W-1:0]             in_encoder_in,
  input  logic signed [mftr_pkg::SPD_W-1:0]      in_speed_in,
  input  logic signed [mftr_pkg::CUR_W-1:0]      in_current_in,
  input  logic [mftr_pkg::TEMP_W-1:0]            in_temp_in,
  // result queue side
  output logic                                   empty,
  input  logic                                   pop,
  output logic [mftr_pkg::SLOT_W-1:0]            out_motor_slot,
  output logic [mftr_pkg::ENC_W-1:0]             out_encoder_out,
  output logic signed [mftr_pkg::SPD_W-1:0]      out_speed_out,
  output logic signed [mftr_pkg::CUR_W-1:0]      out_current_out,
  output logic [mftr_pkg::TEMP_W-1:0]            out_temp_out,
  output logic signed [mftr_pkg::TURN_W-1:0]     out_turn_count,
  output logic signed [mftr_pkg::ANGLE_W-1:0]    out_abs_position
);

  mftr_pkg::q_wr_t     mid_wr;
  mftr_pkg::cls_item_t mid_in, mid_out;
  logic                mid_full, mid_empty, mid_pop;
  mftr_pkg::q_wr_t     res_wr;
  mftr_pkg::res_item_t res_in, res_out;
  logic                res_full;

  // Classify incoming frames
  mftr_front #(.NUM_MOTORS(NUM_MOTORS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_push       (push),
    .in_bus_select (in_bus_select),
    .in_frame_id   (in_frame_id),
    .in_encoder_in (in_encoder_in),
    .in_speed_in   (in_speed_in),
    .in_current_in (in_current_in),
    .in_temp_in    (in_temp_in),
    .mid_wr        (mid_wr),
    .mid_full      (mid_full),
    .mid_item      (mid_in)
  );

  assign full = mid_wr.full;

  // Decouple classify from update
  mftr_fifo #(.WIDTH($bits(mftr_pkg::cls_item_t)), .DEPTH(mftr_pkg::MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_wr.push),
    .wdata (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty)
  );

  // Track turns per slot
  mftr_back #(.NUM_MOTORS(NUM_MOTORS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_out),
    .mid_pop   (mid_pop),
    .res_wr    (res_wr),
    .res_full  (res_full),
    .res_item  (res_in)
  );

  // Hold finished results for the receiver
  mftr_fifo #(.WIDTH($bits(mftr_pkg::res_item_t)), .DEPTH(mftr_pkg::OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_wr.push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_motor_slot   = res_out.slot;
  assign out_encoder_out  = res_out.enc;
  assign out_speed_out    = res_out.speed;
  assign out_current_out  = res_out.current;
  assign out_temp_out     = res_out.temp;
  assign out_turn_count   = res_out.turns;
  assign out_abs_position = res_out.angle;

  // Queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("result queue not empty after reset");

  // Only configured slots appear
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (32'(out_motor_slot) < NUM_MOTORS) && (out_motor_slot < 3'd6))
    else $error("result slot out of range");

  // Position agrees with turn count and encoder
  a_angle: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_abs_position ==
      $signed({out_turn_count[mftr_pkg::TURN_W-1], out_turn_count,
               {mftr_pkg::TICK_SHIFT{1'b0}}})
      + $signed({{(mftr_pkg::ANGLE_W - mftr_pkg::ENC_W){1'b0}}, out_encoder_out})))
    else $error("absolute position mismatch");

  // The back never writes into a full result queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr.push |-> !res_wr.full)
    else $error("result queue overrun");

  // A waiting result holds until it is taken
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(res_out)))
    else $error("waiting result changed");

endmodule

@@ hw/rtl/mftr_fifo.sv @@
`timescale 1ns / 1ps

module mftr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ hw/rtl/mftr_front.sv @@
`timescale 1ns / 1ps

module mftr_front #(
  parameter int NUM_MOTORS = mftr_pkg::NUM_MOTORS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // identifier registers
  input  logic                                  cfg_we,
  input  logic [mftr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mftr_pkg::ID_W-1:0]             cfg_wdata,
  // incoming frame
  input  logic                                  in_push,
  input  logic                                  in_bus_select,
  input  logic [mftr_pkg::ID_W-1:0]             in_frame_id,
  input  logic [mftr_pkg::ENC_W-1:0]            in_encoder_in,
  input  logic signed [mftr_pkg::SPD_W-1:0]     in_speed_in,
  input  logic signed [mftr_pkg::CUR_W-1:0]     in_current_in,
  input  logic [mftr_pkg::TEMP_W-1:0]           in_temp_in,
  // toward the middle queue
  output mftr_pkg::q_wr_t                       mid_wr,
  input  logic                                  mid_full,
  output mftr_pkg::cls_item_t                   mid_item
);

  localparam int MATCH_N = (NUM_MOTORS < mftr_pkg::NUM_ID_REGS) ?
                           NUM_MOTORS : mftr_pkg::NUM_ID_REGS;

  logic [mftr_pkg::ID_W-1:0]   id_r [mftr_pkg::NUM_ID_REGS];
  logic                        hit;
  logic [mftr_pkg::SLOT_W-1:0] hit_slot;

  // Write identifier registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mftr_pkg::NUM_ID_REGS; i++) begin
        id_r[i] <= mftr_pkg::ID_W'(mftr_pkg::ID_RESET_BASE + i);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        mftr_pkg::CFG_FRONT_LEFT_ID:  id_r[0] <= cfg_wdata;
        mftr_pkg::CFG_REAR_LEFT_ID:   id_r[1] <= cfg_wdata;
        mftr_pkg::CFG_FRONT_RIGHT_ID: id_r[2] <= cfg_wdata;
        mftr_pkg::CFG_REAR_RIGHT_ID:  id_r[3] <= cfg_wdata;
        mftr_pkg::CFG_FEEDER_ID:      id_r[4] <= cfg_wdata;
        mftr_pkg::CFG_TURRET_ID:      id_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Match the identifier; scan downward so the lowest slot wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = MATCH_N - 1; i >= 0; i--) begin
      if (id_r[i] == in_frame_id) begin
        hit      = 1'b1;
        hit_slot = mftr_pkg::SLOT_W'(i);
      end
    end
  end

  // Pass only first-bus frames that hit a slot; others are dropped on accept
  assign mid_wr.push = in_push && !mid_full && !in_bus_select && hit;
  assign mid_wr.full = mid_full;

  assign mid_item.slot    = hit_slot;
  assign mid_item.enc     = in_encoder_in;
  assign mid_item.speed   = in_speed_in;
  assign mid_item.current = in_current_in;
  assign mid_item.temp    = in_temp_in;

endmodule

@@ hw/rtl/mftr_back.sv @@
`timescale 1ns / 1ps

module mftr_back #(
  parameter int NUM_MOTORS = mftr_pkg::NUM_MOTORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // from the middle queue
  input  logic                 mid_empty,
  input  mftr_pkg::cls_item_t  mid_item,
  output logic                 mid_pop,
  // toward the result queue
  output mftr_pkg::q_wr_t      res_wr,
  input  logic                 res_full,
  output mftr_pkg::res_item_t  res_item
);

  localparam int SIDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int DIFF_W = mftr_pkg::ENC_W + 1;

  logic        [mftr_pkg::ENC_W-1:0]  enc_r  [NUM_MOTORS];
  logic signed [mftr_pkg::TURN_W-1:0] turn_r [NUM_MOTORS];

  logic        [SIDX_W-1:0]           sidx;
  logic        [mftr_pkg::ENC_W-1:0]  last_enc;
  logic signed [mftr_pkg::TURN_W-1:0] turn_cur;
  logic signed [mftr_pkg::TURN_W-1:0] turn_nxt;
  logic signed [DIFF_W-1:0]           diff;
  logic                               step;

  assign step     = !mid_empty && !res_full;
  assign mid_pop  = step;
  assign sidx     = mid_item.slot[SIDX_W-1:0];
  assign last_enc = enc_r[sidx];
  assign turn_cur = turn_r[sidx];
  assign diff     = $signed({1'b0, mid_item.enc}) - $signed({1'b0, last_enc});

  // Count a turn on a large jump, hold at the range bounds
  always_comb begin
    turn_nxt = turn_cur;
    if (diff > $signed(DIFF_W'(mftr_pkg::JUMP_LIMIT))) begin
      if (turn_cur != mftr_pkg::TURN_MIN) begin
        turn_nxt = turn_cur - $signed(mftr_pkg::TURN_W'(1));
      end
    end else if (diff < -$signed(DIFF_W'(mftr_pkg::JUMP_LIMIT))) begin
      if (turn_cur != mftr_pkg::TURN_MAX) begin
        turn_nxt = turn_cur + $signed(mftr_pkg::TURN_W'(1));
      end
    end
  end

  // Update the slot record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        enc_r[i]  <= '0;
        turn_r[i] <= '0;
      end
    end else if (step) begin
      enc_r[sidx]  <= mid_item.enc;
      turn_r[sidx] <= turn_nxt;
    end
  end

  // Build the result: turns * 8192 + encoder
  assign res_wr.push = step;
  assign res_wr.full = res_full;

  assign res_item.slot    = mid_item.slot;
  assign res_item.enc     = mid_item.enc;
  assign res_item.speed   = mid_item.speed;
  assign res_item.current = mid_item.current;
  assign res_item.temp    = mid_item.temp;
  assign res_item.turns   = turn_nxt;
  assign res_item.angle   = $signed({turn_nxt[mftr_pkg::TURN_W-1], turn_nxt,
                                      {mftr_pkg::TICK_SHIFT{1'b0}}})
                          + $signed({{(mftr_pkg::ANGLE_W - mftr_pkg::ENC_W){1'b0}},
                                      mid_item.enc});

endmodule
